// File: rtl/ctg_pkg.sv
// shared types, constants and the temperature curve table function
package ctg_pkg;

    localparam int KELVIN_W  = 16;
    localparam int GAMMA_W   = 10;
    localparam int LEVEL_W   = 16;
    localparam int GAIN_W    = 26;
    localparam int INDEX_W   = 8;
    localparam int ROM_DEPTH = 1 << INDEX_W;

    localparam logic [KELVIN_W-1:0] KELVIN_MIN = 16'd1000;
    localparam logic [KELVIN_W-1:0] KELVIN_MAX = 16'd20000;
    localparam int INDEX_MIN     = 10;
    localparam int INDEX_MAX     = 200;
    localparam int WARM_LIMIT    = 66;
    localparam int NO_BLUE_LIMIT = 19;

    // kelvin / 100 as (kelvin * 5243) >> 19, exact over the accepted range
    localparam int DIV100_MUL_W = 13;
    localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 13'd5243;
    localparam int DIV100_SHIFT = 19;

    localparam logic [GAMMA_W-1:0] MAX_GAMMA_RESET = 10'd100;
    localparam logic [GAIN_W-1:0]  UNITY_GAIN      = 26'd6528000;
    localparam logic [LEVEL_W-1:0] FULL_LEVEL      = 16'd65280;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_KELVIN = 2'd1,
        ST_GAMMA  = 2'd2
    } ctg_status_t;

    typedef struct packed {
        logic [KELVIN_W-1:0] kelvin;
        logic [GAMMA_W-1:0]  gamma_percent;
        logic                identity;
    } ctg_in_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [GAIN_W-1:0] red_level;
        logic [GAIN_W-1:0] green_level;
        logic [GAIN_W-1:0] blue_level;
    } ctg_out_t;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [GAMMA_W-1:0] gamma_percent;
        logic               identity;
        ctg_status_t        status;
    } ctg_stage_t;

    // q8.8 channel level at t = kelvin / 100, evaluated at elaboration only
    function automatic logic [LEVEL_W-1:0] curve_level(input int t, input int ch);
        real v;
        int  q;
        v = 0.0;
        if (t >= INDEX_MIN && t <= INDEX_MAX) begin
            if (t <= WARM_LIMIT) begin
                case (ch)
                    CH_RED:   v = 255.0;
                    CH_GREEN: v = 99.4708025861 * $ln(real'(t)) - 161.1195681661;
                    CH_BLUE:
                    begin
                        if (t <= NO_BLUE_LIMIT)
                            v = 0.0;
                        else
                            v = 138.5177312231 * $ln(real'(t - 10)) - 305.0447927307;
                    end
                    default:  v = 0.0;
                endcase
            end
            else begin
                case (ch)
                    CH_RED:   v = 329.698727446 * $pow(real'(t - 60), -0.1332047592);
                    CH_GREEN: v = 288.1221695283 * $pow(real'(t - 60), -0.0755148492);
                    CH_BLUE:  v = 255.0;
                    default:  v = 0.0;
                endcase
            end
        end
        if (v < 0.0)
            v = 0.0;
        if (v > 255.0)
            v = 255.0;
        q = $rtoi(v * 256.0 + 0.5);
        return LEVEL_W'(q);
    endfunction

endpackage

// File: rtl/ctg_front.sv
// input register: acceptance, range checks, table index and max gamma register
module ctg_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  ctg_pkg::ctg_in_t  in_data,
    input  logic              cfg_we,
    input  logic [ctg_pkg::GAMMA_W-1:0] cfg_data,
    input  logic              s1_ready,
    output logic              s1_valid,
    output ctg_pkg::ctg_stage_t s1_data
);

    logic                           s1_valid_reg;
    logic                           s1_valid_next;
    ctg_pkg::ctg_stage_t            s1_data_reg;
    ctg_pkg::ctg_stage_t            s1_data_next;
    logic [ctg_pkg::GAMMA_W-1:0]    max_gamma_reg;
    logic [ctg_pkg::GAMMA_W-1:0]    max_gamma_next;
    logic                           take;
    logic [ctg_pkg::KELVIN_W+ctg_pkg::DIV100_MUL_W-1:0] div_prod;

    assign in_stall = s1_valid_reg && !s1_ready;
    assign take     = in_valid && !in_stall;
    assign div_prod = {{ctg_pkg::DIV100_MUL_W{1'b0}}, in_data.kelvin}
                    * {{ctg_pkg::KELVIN_W{1'b0}}, ctg_pkg::DIV100_MUL};

    always_comb
    begin
        s1_data_next               = s1_data_reg;
        s1_valid_next              = s1_valid_reg;
        max_gamma_next             = cfg_we ? cfg_data : max_gamma_reg;
        if (take)
        begin
            s1_valid_next               = 1'b1;
            s1_data_next.index          = div_prod[ctg_pkg::DIV100_SHIFT +: ctg_pkg::INDEX_W];
            s1_data_next.gamma_percent  = in_data.gamma_percent;
            s1_data_next.identity       = in_data.identity;
            if (in_data.kelvin < ctg_pkg::KELVIN_MIN || in_data.kelvin > ctg_pkg::KELVIN_MAX)
                s1_data_next.status = ctg_pkg::ST_KELVIN;
            else if (in_data.gamma_percent > max_gamma_reg)
                s1_data_next.status = ctg_pkg::ST_GAMMA;
            else
                s1_data_next.status = ctg_pkg::ST_OK;
        end
        else if (s1_ready)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            max_gamma_reg <= ctg_pkg::MAX_GAMMA_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            max_gamma_reg <= max_gamma_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_data_reg <= s1_data_next;
    end

    assign s1_valid = s1_valid_reg;
    assign s1_data  = s1_data_reg;

    // an accepted temperature always lands on a populated table row
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_data_reg.status == ctg_pkg::ST_OK) |->
        (s1_data_reg.index >= ctg_pkg::INDEX_W'(ctg_pkg::INDEX_MIN)
         && s1_data_reg.index <= ctg_pkg::INDEX_W'(ctg_pkg::INDEX_MAX)))
        else $error("table index outside populated range");

    // a held item is not overwritten
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_ready) |=> (s1_valid_reg && $stable(s1_data_reg)))
        else $error("stage register changed while blocked");

endmodule

// File: rtl/ctg_gain.sv
// curve table, gamma multiplies, held gains and result register
module ctg_gain (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s1_valid,
    input  ctg_pkg::ctg_stage_t s1_data,
    output logic                s1_ready,
    output logic                out_valid,
    input  logic                out_stall,
    output ctg_pkg::ctg_out_t   out_data
);

    logic [ctg_pkg::LEVEL_W-1:0] red_rom   [ctg_pkg::ROM_DEPTH];
    logic [ctg_pkg::LEVEL_W-1:0] green_rom [ctg_pkg::ROM_DEPTH];
    logic [ctg_pkg::LEVEL_W-1:0] blue_rom  [ctg_pkg::ROM_DEPTH];

    for (genvar i = 0; i < ctg_pkg::ROM_DEPTH; i++)
    begin : g_rom
        localparam logic [ctg_pkg::LEVEL_W-1:0] R = ctg_pkg::curve_level(i, ctg_pkg::CH_RED);
        localparam logic [ctg_pkg::LEVEL_W-1:0] G = ctg_pkg::curve_level(i, ctg_pkg::CH_GREEN);
        localparam logic [ctg_pkg::LEVEL_W-1:0] B = ctg_pkg::curve_level(i, ctg_pkg::CH_BLUE);
        assign red_rom[i]   = R;
        assign green_rom[i] = G;
        assign blue_rom[i]  = B;
    end

    logic [ctg_pkg::LEVEL_W-1:0] red_lvl;
    logic [ctg_pkg::LEVEL_W-1:0] green_lvl;
    logic [ctg_pkg::LEVEL_W-1:0] blue_lvl;
    logic [ctg_pkg::GAIN_W-1:0]  red_gain;
    logic [ctg_pkg::GAIN_W-1:0]  green_gain;
    logic [ctg_pkg::GAIN_W-1:0]  blue_gain;
    logic                        advance;
    logic                        update;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    ctg_pkg::ctg_out_t           out_data_reg;
    ctg_pkg::ctg_out_t           out_data_next;
    logic [ctg_pkg::GAIN_W-1:0]  held_red_reg;
    logic [ctg_pkg::GAIN_W-1:0]  held_green_reg;
    logic [ctg_pkg::GAIN_W-1:0]  held_blue_reg;
    logic [ctg_pkg::GAIN_W-1:0]  held_red_next;
    logic [ctg_pkg::GAIN_W-1:0]  held_green_next;
    logic [ctg_pkg::GAIN_W-1:0]  held_blue_next;

    assign s1_ready = !out_valid_reg || !out_stall;
    assign advance  = s1_valid && s1_ready;
    assign update   = advance && (s1_data.status == ctg_pkg::ST_OK);

    assign red_lvl   = s1_data.identity ? ctg_pkg::FULL_LEVEL : red_rom[s1_data.index];
    assign green_lvl = s1_data.identity ? ctg_pkg::FULL_LEVEL : green_rom[s1_data.index];
    assign blue_lvl  = s1_data.identity ? ctg_pkg::FULL_LEVEL : blue_rom[s1_data.index];

    assign red_gain   = {{ctg_pkg::GAMMA_W{1'b0}}, red_lvl}
                      * {{ctg_pkg::LEVEL_W{1'b0}}, s1_data.gamma_percent};
    assign green_gain = {{ctg_pkg::GAMMA_W{1'b0}}, green_lvl}
                      * {{ctg_pkg::LEVEL_W{1'b0}}, s1_data.gamma_percent};
    assign blue_gain  = {{ctg_pkg::GAMMA_W{1'b0}}, blue_lvl}
                      * {{ctg_pkg::LEVEL_W{1'b0}}, s1_data.gamma_percent};

    always_comb
    begin
        held_red_next   = update ? red_gain   : held_red_reg;
        held_green_next = update ? green_gain : held_green_reg;
        held_blue_next  = update ? blue_gain  : held_blue_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg && out_stall;
        if (advance)
        begin
            out_valid_next            = 1'b1;
            out_data_next.status      = 2'(s1_data.status);
            out_data_next.red_level   = held_red_next;
            out_data_next.green_level = held_green_next;
            out_data_next.blue_level  = held_blue_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            held_red_reg   <= ctg_pkg::UNITY_GAIN;
            held_green_reg <= ctg_pkg::UNITY_GAIN;
            held_blue_reg  <= ctg_pkg::UNITY_GAIN;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            held_red_reg   <= held_red_next;
            held_green_reg <= held_green_next;
            held_blue_reg  <= held_blue_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // the pending result always mirrors the held gains
    a_out_is_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.red_level == held_red_reg
                           && out_data_reg.green_level == held_green_reg
                           && out_data_reg.blue_level == held_blue_reg))
        else $error("result differs from held gains");

    // held gains move only on an accepted request that passed both checks
    a_held_update: assert property (@(posedge clk) disable iff (!rst_n)
        !update |=> ($stable(held_red_reg) && $stable(held_green_reg)
                     && $stable(held_blue_reg)))
        else $error("held gains changed without an ok request");

    // a rejected request leaves its status in the result
    a_reject_status: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_data.status != ctg_pkg::ST_OK) |=>
        (out_valid_reg && out_data_reg.status != 2'(ctg_pkg::ST_OK)))
        else $error("rejected request reported as ok");

endmodule

// File: rtl/color_temperature_gain_matrix.sv
// top level of the colour temperature gain matrix
// path: an accepted transaction is registered in the input stage register, then in the result register
// throughput: one transaction per cycle while out_stall is low, set by the single input stage and result register
// the result register frees itself in the same cycle its transaction is taken downstream
// reset: asynchronous, active low; clears both valids, max gamma to 100, held gains to unity
// no clearing pass: the curve table is constant logic
module color_temperature_gain_matrix (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  ctg_pkg::ctg_in_t             in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output ctg_pkg::ctg_out_t            out_data,
    input  logic                         cfg_we,
    input  logic [ctg_pkg::GAMMA_W-1:0]  cfg_data
);

    // stage between the input register and the gain logic
    logic                s1_valid;
    logic                s1_ready;
    ctg_pkg::ctg_stage_t s1_data;

    // front end: takes a transaction, checks temperature then gamma, forms kelvin / 100
    ctg_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s1_ready (s1_ready),
        .s1_valid (s1_valid),
        .s1_data  (s1_data)
    );

    // back end: curve lookup per channel, three gamma multiplies, held gains and
    // result register; a rejected transaction repeats the held gains
    ctg_gain u_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid),
        .s1_data   (s1_data),
        .s1_ready  (s1_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
